>>> src/rme_pkg.sv
// Shared constants and arctangent table for the rotation-matrix-to-Euler block.
// Depends on nothing; used by rme_cordic.
package rme_pkg;
	localparam int ANGW = 36;
	localparam logic signed [ANGW-1:0] ANG_PI = 36'sd3373259426;
	localparam int OUT_PI = 25736;

	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] t;
		begin
			unique case (i)
				5'd0: t = 32'h3243F6A8; 5'd1: t = 32'h1DAC6705; 5'd2: t = 32'h0FADBAFC;
				5'd3: t = 32'h07F56EA6; 5'd4: t = 32'h03FEAB76; 5'd5: t = 32'h01FFD55B;
				5'd6: t = 32'h00FFFAAA; 5'd7: t = 32'h007FFF55; 5'd8: t = 32'h003FFFEA;
				5'd9: t = 32'h001FFFFD; 5'd10: t = 32'h000FFFFF; 5'd11: t = 32'h0007FFFF;
				5'd12: t = 32'h0003FFFF; 5'd13: t = 32'h0001FFFF; 5'd14: t = 32'h0000FFFF;
				5'd15: t = 32'h00007FFF; 5'd16: t = 32'h00003FFF; 5'd17: t = 32'h00001FFF;
				5'd18: t = 32'h00000FFF; 5'd19: t = 32'h000007FF; 5'd20: t = 32'h000003FF;
				5'd21: t = 32'h000001FF; 5'd22: t = 32'h000000FF; 5'd23: t = 32'h0000007F;
				5'd24: t = 32'h0000003F; 5'd25: t = 32'h0000001F; 5'd26: t = 32'h0000000F;
				5'd27: t = 32'h00000008; 5'd28: t = 32'h00000004; 5'd29: t = 32'h00000002;
				5'd30: t = 32'h00000001; default: t = 32'h00000000;
			endcase
			return t;
		end
	endfunction
endpackage

>>> src/rme_front.sv
// Front end: squares, pipelined integer square root of m00^2+m10^2,
// threshold compare and operand selection.
module rme_front #(
	parameter int EW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_v,
	input  logic signed [EW-1:0] m00, m10, m20, m21, m22, m11, m12,
	input  logic [14:0]          thr,
	output logic                 out_v,
	output logic signed [EW:0]   ry, rx, py, px, yy, yx,
	output logic                 sing
);
	localparam int SW = 2*EW + 2;
	localparam int RW = EW + 1;
	localparam int NS = RW;

	logic [SW-1:0] rem_s [0:NS];
	logic [RW-1:0] root_s [0:NS];
	logic          v_s [0:NS];
	logic signed [EW-1:0] e_s [0:NS][0:6];
	logic [SW-1:0] sq0, sq1;

	assign sq0 = SW'(unsigned'(34'(m00) * 34'(m00)));
	assign sq1 = SW'(unsigned'(34'(m10) * 34'(m10)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_v;
		end
	end
	always_ff @(posedge clk) begin
		rem_s[0] <= sq0 + sq1;
		root_s[0] <= '0;
		e_s[0][0] <= m00; e_s[0][1] <= m10; e_s[0][2] <= m20; e_s[0][3] <= m21;
		e_s[0][4] <= m22; e_s[0][5] <= m11; e_s[0][6] <= m12;
	end

	// digit-by-digit root, one result bit per stage
	for (genvar k = 0; k < NS; k++) begin : g_sq
		localparam int B = NS - 1 - k;
		logic [SW+1:0] trial, r2;
		assign r2 = (SW+2)'(root_s[k]) << (B + 1);
		assign trial = r2 + ((SW+2)'(1) << (2*B));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if ((SW+2)'(rem_s[k]) >= trial) begin
				rem_s[k+1]  <= SW'((SW+2)'(rem_s[k]) - trial);
				root_s[k+1] <= root_s[k] | (RW'(1) << B);
			end else begin
				rem_s[k+1]  <= rem_s[k];
				root_s[k+1] <= root_s[k];
			end
			e_s[k+1] <= e_s[k];
		end
	end

	logic s;
	assign s = root_s[NS] < RW'(thr);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else begin
			out_v <= v_s[NS];
		end
	end
	always_ff @(posedge clk) begin
		sing <= s;
		py <= -(RW'(e_s[NS][2]));
		px <= $signed(root_s[NS]);
		yy <= RW'(e_s[NS][1]);
		yx <= RW'(e_s[NS][0]);
		ry <= s ? -(RW'(e_s[NS][6])) : RW'(e_s[NS][3]);
		rx <= s ? RW'(e_s[NS][5]) : RW'(e_s[NS][4]);
	end
endmodule

>>> src/rme_cordic.sv
// Pipelined vectoring CORDIC atan2, one stage per iteration, Q3.13 result.
// Uses rme_pkg for the arctangent table and angle constants.
module rme_cordic #(
	parameter int EW = 17,
	parameter int EFB = 14,
	parameter int STAGES = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [EW-1:0] y_in,
	input  logic signed [EW-1:0] x_in,
	output logic signed [15:0]   ang
);
	localparam int AW = rme_pkg::ANGW;
	localparam int XW = EW + (30 - EFB) + 3;

	logic signed [XW-1:0] x_s [0:STAGES];
	logic signed [XW-1:0] y_s [0:STAGES];
	logic signed [AW-1:0] z_s [0:STAGES];
	logic                 zr_s [0:STAGES];

	logic signed [XW-1:0] xi, yi;
	assign xi = XW'(x_in) <<< (30 - EFB);
	assign yi = XW'(y_in) <<< (30 - EFB);

	always_ff @(posedge clk) begin
		if (en) begin
			zr_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				x_s[0] <= -xi; y_s[0] <= -yi;
				z_s[0] <= (y_in >= 0) ? rme_pkg::ANG_PI : -rme_pkg::ANG_PI;
			end else begin
				x_s[0] <= xi; y_s[0] <= yi; z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_st
		localparam int S = i % 32;
		logic signed [AW-1:0] a;
		assign a = AW'(rme_pkg::atan_q30(5'(S)));
		always_ff @(posedge clk) begin
			if (en) begin
				zr_s[i+1] <= zr_s[i];
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> S);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> S);
					z_s[i+1] <= z_s[i] + a;
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> S);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> S);
					z_s[i+1] <= z_s[i] - a;
				end
			end
		end
	end

	logic signed [AW-1:0] r;
	always_comb begin
		r = (z_s[STAGES] + AW'(65536)) >>> 17;
		if (zr_s[STAGES])
			ang = '0;
		else if (r > AW'(rme_pkg::OUT_PI))
			ang = 16'(rme_pkg::OUT_PI);
		else if (r < -AW'(rme_pkg::OUT_PI))
			ang = -16'(rme_pkg::OUT_PI);
		else
			ang = 16'(r);
	end
endmodule

>>> src/rme_back.sv
// Back end: three CORDIC pipelines with a valid line, stalled as one.
// Uses rme_cordic.
module rme_back #(
	parameter int EFB = 14,
	parameter int STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_v,
	input  logic signed [16:0] ry, rx, py, px, yy, yx,
	input  logic               sing_in,
	output logic               out_v,
	output logic signed [15:0] roll, pitch, yaw,
	output logic               sing
);
	logic [STAGES:0] v_q, s_q;
	logic signed [15:0] ya;

	rme_cordic #(.EW(17), .EFB(EFB), .STAGES(STAGES)) u_r (
		.clk(clk), .en(en), .y_in(ry), .x_in(rx), .ang(roll));
	rme_cordic #(.EW(17), .EFB(EFB), .STAGES(STAGES)) u_p (
		.clk(clk), .en(en), .y_in(py), .x_in(px), .ang(pitch));
	rme_cordic #(.EW(17), .EFB(EFB), .STAGES(STAGES)) u_y (
		.clk(clk), .en(en), .y_in(yy), .x_in(yx), .ang(ya));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[STAGES-1:0], in_v};
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			s_q <= {s_q[STAGES-1:0], sing_in};
		end
	end
	assign out_v = v_q[STAGES];
	assign sing  = s_q[STAGES];
	assign yaw   = sing ? 16'sd0 : ya;
endmodule

>>> src/rotation_matrix_to_euler.sv
// From an accepted request to its result on the ports, a matrix passes the front
// (input register, 17 root stages, output register), the queue between the parts,
// and the back (CORDIC input register, CORDIC_STAGES stages), into the result queue.
// Throughput: one matrix per cycle while full is low; 63 credits cover all requests
// in flight; the front takes a request every cycle, the back each unstalled cycle.
// Reset (arst_n low, asynchronous) empties all queues; threshold returns to 1.
module rotation_matrix_to_euler #(
	parameter int ELEM_FRAC_BITS = 14,
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [14:0]        cfg_wdata,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] m00, m10, m20, m21, m22, m11, m12,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] roll, pitch, yaw,
	output logic               singular
);
	localparam int QD = 32;          // front queue depth
	localparam int QA = $clog2(QD);
	localparam int OD = 32;          // result queue depth
	localparam int OA = $clog2(OD);
	// the back stalls only with OD-1 results waiting, so the front queue
	// then holds at most the remaining QD requests
	localparam int CRED = QD + OD - 1;
	localparam int PW = 6*17 + 1;

	logic [14:0] thr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 15'd1;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// Credit counter: admit a request only when the queues can hold every
	// request that is in flight, so nothing is dropped under any stall.
	logic [7:0] cred_q;
	logic acc, rel;
	assign acc  = push && !full;
	assign rel  = pop && !empty;
	assign full = cred_q == 8'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cred_q <= 8'(CRED);
		end else begin
			cred_q <= cred_q - 8'(acc) + 8'(rel);
		end
	end

	logic fv, fs;
	logic signed [16:0] ry, rx, py, px, yy, yx;
	rme_front #(.EW(16)) u_front (
		.clk(clk), .arst_n(arst_n), .in_v(acc),
		.m00(m00), .m10(m10), .m20(m20), .m21(m21), .m22(m22), .m11(m11), .m12(m12),
		.thr(thr_q), .out_v(fv), .ry(ry), .rx(rx), .py(py), .px(px), .yy(yy), .yx(yx),
		.sing(fs));

	// front-to-back queue
	logic [PW-1:0] fq_mem [0:QD-1];
	logic [QA:0] fw_q, fr_q;
	logic [PW-1:0] fq_rd;
	logic fq_ne, bk_en, bk_v, bo_v, bs;
	logic signed [15:0] br, bp, by;
	logic [OA:0] ow_q, or_q;
	logic [OA:0] ocnt;
	// hold the back pipeline while the result queue holds OD-1 or more results
	assign ocnt  = ow_q - or_q;
	assign bk_en = ocnt < (OA+1)'(OD - 1);
	assign fq_ne = fw_q != fr_q;
	assign fq_rd = fq_mem[fr_q[QA-1:0]];

	always_ff @(posedge clk) begin
		if (fv) begin
			fq_mem[fw_q[QA-1:0]] <= {ry, rx, py, px, yy, yx, fs};
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= '0;
			fr_q <= '0;
		end else begin
			if (fv) fw_q <= fw_q + 1'b1;
			if (bk_en && fq_ne) fr_q <= fr_q + 1'b1;
		end
	end

	rme_back #(.EFB(ELEM_FRAC_BITS), .STAGES(CORDIC_STAGES)) u_back (
		.clk(clk), .arst_n(arst_n), .en(bk_en), .in_v(fq_ne),
		.ry(fq_rd[PW-1 -: 17]), .rx(fq_rd[PW-18 -: 17]), .py(fq_rd[PW-35 -: 17]),
		.px(fq_rd[PW-52 -: 17]), .yy(fq_rd[PW-69 -: 17]), .yx(fq_rd[PW-86 -: 17]),
		.sing_in(fq_rd[0]), .out_v(bo_v), .roll(br), .pitch(bp), .yaw(by), .sing(bs));

	// result queue
	logic [48:0] oq_mem [0:OD-1];
	logic ow_push;
	assign ow_push = bo_v && bk_en;
	always_ff @(posedge clk) begin
		if (ow_push) begin
			oq_mem[ow_q[OA-1:0]] <= {br, bp, by, bs};
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ow_q <= '0;
			or_q <= '0;
		end else begin
			if (ow_push) ow_q <= ow_q + 1'b1;
			if (rel) or_q <= or_q + 1'b1;
		end
	end
	assign empty = ow_q == or_q;
	assign {roll, pitch, yaw, singular} = oq_mem[or_q[OA-1:0]];
endmodule
